// ===== hdl/rar_pkg.sv =====
package rar_pkg;

	typedef enum logic [1:0] {
		FUNC_ADD = 2'd0,
		FUNC_SUB = 2'd1,
		FUNC_MUL = 2'd2,
		FUNC_DIV = 2'd3
	} func_t;

	localparam int unsigned NUM_W = 63;
	localparam int unsigned DEN_W = 61;
	localparam int unsigned MAG_W = 62;

	// raw fraction handed from front to back
	typedef struct packed {
		logic             rn_neg;
		logic             rd_neg;
		logic [MAG_W-1:0] nm;
		logic [MAG_W-1:0] dm;
	} raw_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_GCD,
		BK_DIVN,
		BK_DIVD,
		BK_DONE
	} bk_state_t;

endpackage

// ===== hdl/rar_front.sv =====
module rar_front #(
	parameter int OPERAND_WIDTH = 31
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                func,
	input  logic [OPERAND_WIDTH-1:0]  a_num,
	input  logic [OPERAND_WIDTH-1:0]  a_den,
	input  logic [OPERAND_WIDTH-1:0]  b_num,
	input  logic [OPERAND_WIDTH-1:0]  b_den,
	output logic                      out_valid,
	input  logic                      out_ready,
	output rar_pkg::raw_t             out_raw
);
	import rar_pkg::*;

	localparam int PW = 2 * OPERAND_WIDTH;

	logic              v_s1, v_s2;
	func_t             func_s1;
	logic signed [PW-1:0] p0_s1, p1_s1, pd_s1;
	logic signed [PW:0]   rn_s2, rd_s2;
	logic signed [OPERAND_WIDTH-1:0] an, ad, bn, bd;
	logic signed [PW:0]   rn_c, rd_c;
	logic adv2, adv1;

	assign an = a_num;
	assign ad = a_den;
	assign bn = b_num;
	assign bd = b_den;

	assign adv2 = !v_s2 || out_ready;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	// stage 1: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv1) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			func_s1 <= func_t'(func);
			p0_s1 <= (func == FUNC_MUL) ? an * bn : an * bd;
			p1_s1 <= bn * ad;
			pd_s1 <= (func == FUNC_DIV) ? ad * bn : ad * bd;
		end
	end

	// stage 2: combine products
	always_comb begin
		rd_c = {pd_s1[PW-1], pd_s1};
		case (func_s1)
			FUNC_ADD: rn_c = {p0_s1[PW-1], p0_s1} + {p1_s1[PW-1], p1_s1};
			FUNC_SUB: rn_c = {p0_s1[PW-1], p0_s1} - {p1_s1[PW-1], p1_s1};
			default:  rn_c = {p0_s1[PW-1], p0_s1};
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv2) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			rn_s2 <= rn_c;
			rd_s2 <= rd_c;
		end
	end

	// magnitudes, sign flags
	logic [PW:0] nmag, dmag;
	assign nmag = rn_s2[PW] ? -rn_s2 : rn_s2;
	assign dmag = rd_s2[PW] ? -rd_s2 : rd_s2;
	assign out_valid = v_s2;
	assign out_raw.rn_neg = rn_s2[PW];
	assign out_raw.rd_neg = rd_s2[PW];
	assign out_raw.nm = MAG_W'(nmag);
	assign out_raw.dm = MAG_W'(dmag);

endmodule

// ===== hdl/rar_back.sv =====
module rar_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  rar_pkg::raw_t                 in_raw,
	output logic                          empty,
	input  logic                          pop,
	output logic [rar_pkg::NUM_W-1:0]     res_num,
	output logic [rar_pkg::DEN_W-1:0]     res_den,
	output logic                          div_zero
);
	import rar_pkg::*;

	localparam int CW = $clog2(MAG_W + 1);

	bk_state_t state_q, state_d;
	logic [MAG_W-1:0] x_q, y_q, nm_q, dm_q, g_q, rem_q, quo_q, dvd_q;
	logic [CW-1:0]    cnt_q;
	logic             neg_q, zero_q;

	// one restoring step, shared by gcd remainders and exact divides
	logic [MAG_W-1:0] div_den;
	logic [MAG_W:0]   trial;
	logic [MAG_W-1:0] rem_sh;
	assign div_den = (state_q == BK_GCD) ? y_q : g_q;
	assign rem_sh = {rem_q[MAG_W-2:0], dvd_q[MAG_W-1]};
	assign trial = {1'b0, rem_sh} - {1'b0, div_den};

	logic last;
	assign last = (cnt_q == CW'(MAG_W - 1));
	logic [MAG_W-1:0] rem_n, quo_n;
	assign rem_n = (trial[MAG_W] || rem_q[MAG_W-1]) && !(rem_q[MAG_W-1])
		? rem_sh : (trial[MAG_W] && !rem_q[MAG_W-1] ? rem_sh : MAG_W'(trial));
	assign quo_n = {quo_q[MAG_W-2:0], !trial[MAG_W] || rem_q[MAG_W-1]};

	assign in_ready = (state_q == BK_IDLE);
	assign empty = (state_q != BK_DONE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (in_valid) state_d = (in_raw.dm == '0) ? BK_DONE : BK_GCD;
			BK_GCD:  if (y_q == '0) state_d = BK_DIVN;
			BK_DIVN: if (last) state_d = BK_DIVD;
			BK_DIVD: if (last) state_d = BK_DONE;
			BK_DONE: if (pop) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else state_q <= state_d;
	end

	// datapath: load, euclid via bit-serial remainder, then two divides
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (state_q == BK_IDLE || (state_q == BK_GCD && y_q == '0)) cnt_q <= '0;
		else if (state_q == BK_GCD || state_q == BK_DIVN || state_q == BK_DIVD)
			cnt_q <= last ? '0 : cnt_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: if (in_valid) begin
				nm_q <= in_raw.nm;
				dm_q <= in_raw.dm;
				x_q <= in_raw.nm;
				y_q <= in_raw.dm;
				dvd_q <= in_raw.nm;
				rem_q <= '0;
				quo_q <= '0;
				neg_q <= in_raw.rn_neg ^ in_raw.rd_neg;
				zero_q <= (in_raw.dm == '0);
			end
			BK_GCD: if (y_q == '0) begin
				g_q <= x_q;
				dvd_q <= nm_q;
				rem_q <= '0;
			end else if (last) begin
				x_q <= y_q;
				y_q <= rem_n;
				dvd_q <= y_q;
				rem_q <= '0;
			end else begin
				rem_q <= rem_n;
				dvd_q <= {dvd_q[MAG_W-2:0], 1'b0};
			end
			BK_DIVN: begin
				quo_q <= quo_n;
				if (last) begin
					nm_q <= quo_n;
					dvd_q <= dm_q;
					rem_q <= '0;
				end else begin
					rem_q <= rem_n;
					dvd_q <= {dvd_q[MAG_W-2:0], 1'b0};
				end
			end
			BK_DIVD: begin
				rem_q <= rem_n;
				quo_q <= quo_n;
				dvd_q <= {dvd_q[MAG_W-2:0], 1'b0};
				if (last) dm_q <= quo_n;
			end
			BK_DONE: ;
			default: ;
		endcase
	end

	logic [NUM_W-1:0] nm_ext;
	assign nm_ext = NUM_W'(nm_q);
	assign res_num = zero_q ? '0 : ((neg_q && nm_q != '0) ? -nm_ext : nm_ext);
	assign res_den = zero_q ? '0 : DEN_W'(dm_q);
	assign div_zero = zero_q;

	a_done_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DONE && !zero_q) |-> (dm_q != '0))
		else $error("zero denominator on valid result");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && div_zero) |-> (res_num == '0 && res_den == '0))
		else $error("error result not cleared");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result dropped");

endmodule

// ===== hdl/rational_arith_reduce.sv =====
// Channel   Handshake       Payload
// input     push / full     func, a_num, a_den, b_num, b_den
// result    empty / pop     res_num, res_den, div_zero
// Front: two registered stages form the raw fraction and can hold two more
// items while the back works. Back: each Euclid remainder step runs one bit a cycle,
// repeated for every remainder, then two exact divides of numerator and denominator
// by the gcd. Zero denominators go straight from idle to done. Reset is asynchronous.
module rational_arith_reduce #(
	parameter int OPERAND_WIDTH = 31
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [1:0]                   func,
	input  logic [OPERAND_WIDTH-1:0]     a_num,
	input  logic [OPERAND_WIDTH-1:0]     a_den,
	input  logic [OPERAND_WIDTH-1:0]     b_num,
	input  logic [OPERAND_WIDTH-1:0]     b_den,
	output logic                         empty,
	input  logic                         pop,
	output logic [rar_pkg::NUM_W-1:0]    res_num,
	output logic [rar_pkg::DEN_W-1:0]    res_den,
	output logic                         div_zero
);
	import rar_pkg::*;

	logic in_ready, mid_valid, mid_ready;
	raw_t mid_raw;

	assign full = !in_ready;

	rar_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
		.clk, .arst_n,
		.in_valid(push), .in_ready,
		.func, .a_num, .a_den, .b_num, .b_den,
		.out_valid(mid_valid), .out_ready(mid_ready), .out_raw(mid_raw)
	);

	rar_back u_back (
		.clk, .arst_n,
		.in_valid(mid_valid), .in_ready(mid_ready), .in_raw(mid_raw),
		.empty, .pop, .res_num, .res_den, .div_zero
	);

endmodule
